### rtl/core/mbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbf_pkg: shared types and constants for the metaball field evaluator
// Formats, grid coordinate table and the cell-to-cell link structures.
// ----------------------------------------------------------------------------
package mbf_pkg;

  localparam int GRID_SIZE  = 32;
  localparam int BALL_COUNT = 3;

  localparam int IDX_W     = 5;
  localparam int IDX_DEPTH = 1 << IDX_W;
  localparam int SLOT_W    = 2;
  localparam int ENERGY_W  = 16;
  localparam int POS_W     = 16;
  localparam int COORD_W   = 20;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MAG_W     = COORD_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int LEN_W     = SQ_W + 2;
  localparam int DIV_SHIFT = 22;
  localparam int DIV_W     = ENERGY_W + DIV_SHIFT;
  localparam int CNT_W     = $clog2(DIV_W);
  localparam int FIELD_W   = 24;

  localparam int HALF_SPAN_Q12 = 20480;
  localparam int SPAN_Q12      = 40960;

  localparam logic [FIELD_W-1:0] FIELD_MAX      = {FIELD_W{1'b1}};
  localparam logic [FIELD_W-1:0] ZERO_DIST_TERM = FIELD_W'(1) << DIV_SHIFT;
  localparam logic [CNT_W-1:0]   DIV_LAST       = CNT_W'(DIV_W - 1);

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [POS_W-1:0]   pos_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vox_t;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    pos_t                x;
    pos_t                y;
    pos_t                z;
  } ball_t;

  typedef struct packed {
    logic diff_en;
    logic sq_en;
    logic len_en;
    logic div_en;
  } ctl_t;

  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] sum;
    logic               sat;
  } link_t;

  function automatic logic [IDX_DEPTH*COORD_W-1:0] build_coord_table();
    logic [IDX_DEPTH*COORD_W-1:0] tbl;
    int i;
    tbl = '0;
    for (i = 0; i < IDX_DEPTH; i++) begin
      tbl[i*COORD_W +: COORD_W] =
        COORD_W'((i * SPAN_Q12 + GRID_SIZE / 2) / GRID_SIZE - HALF_SPAN_Q12);
    end
    return tbl;
  endfunction

  localparam logic [IDX_DEPTH*COORD_W-1:0] COORD_TABLE = build_coord_table();

  function automatic coord_t coord_of(input logic [IDX_W-1:0] idx);
    coord_t c;
    c = COORD_TABLE[idx*COORD_W +: COORD_W];
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/mbf_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbf_cell: one ball of the field chain
// Holds one ball, forms the squared distance to the voxel, divides the energy
// by it bit-serially and adds its term to the running sum from its neighbor.
// ----------------------------------------------------------------------------
module mbf_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire mbf_pkg::ball_t wr_ball,
  input  wire mbf_pkg::ctl_t  ctl,
  input  wire mbf_pkg::vox_t  vox,
  input  wire mbf_pkg::link_t chain_in,
  output mbf_pkg::link_t      chain_out
);
  import mbf_pkg::*;

  logic [ENERGY_W-1:0]      energy;
  pos_t                     pos_x, pos_y, pos_z;
  logic signed [DIFF_W-1:0] diff_x, diff_y, diff_z;
  logic [DIFF_W-1:0]        abs_x, abs_y, abs_z;
  logic [SQ_W-1:0]          sq_x, sq_y, sq_z;
  logic [LEN_W-1:0]         lensq;
  logic [LEN_W-1:0]         rem;
  logic [DIV_W-1:0]         dq;
  logic [LEN_W:0]           shifted, sub;
  logic                     ge;
  logic                     zero_dist, over;
  logic [FIELD_W-1:0]       term;
  logic [FIELD_W:0]         sum_wide;
  logic                     sat_next;
  logic                     link_valid;
  logic [FIELD_W-1:0]       link_sum;
  logic                     link_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy <= '0;
      pos_x  <= '0;
      pos_y  <= '0;
      pos_z  <= '0;
    end else if (wr_en) begin
      energy <= wr_ball.energy;
      pos_x  <= wr_ball.x;
      pos_y  <= wr_ball.y;
      pos_z  <= wr_ball.z;
    end
  end

  always_comb begin
    abs_x = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
    abs_y = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
    abs_z = diff_z[DIFF_W-1] ? DIFF_W'(-diff_z) : DIFF_W'(diff_z);
    shifted = {rem, dq[DIV_W-1]};
    sub     = shifted - {1'b0, lensq};
    ge      = (shifted >= {1'b0, lensq});
  end

  always_ff @(posedge clk) begin
    if (ctl.diff_en) begin
      diff_x <= DIFF_W'(pos_x) - DIFF_W'($signed(vox.x));
      diff_y <= DIFF_W'(pos_y) - DIFF_W'($signed(vox.y));
      diff_z <= DIFF_W'(pos_z) - DIFF_W'($signed(vox.z));
    end
    if (ctl.sq_en) begin
      sq_x <= abs_x[MAG_W-1:0] * abs_x[MAG_W-1:0];
      sq_y <= abs_y[MAG_W-1:0] * abs_y[MAG_W-1:0];
      sq_z <= abs_z[MAG_W-1:0] * abs_z[MAG_W-1:0];
    end
    if (ctl.len_en) begin
      lensq <= LEN_W'(sq_x) + LEN_W'(sq_y) + LEN_W'(sq_z);
      rem   <= '0;
      dq    <= {energy, {DIV_SHIFT{1'b0}}};
    end else if (ctl.div_en) begin
      rem <= ge ? sub[LEN_W-1:0] : shifted[LEN_W-1:0];
      dq  <= {dq[DIV_W-2:0], ge};
    end
  end

  always_comb begin
    zero_dist = (lensq == '0);
    over      = !zero_dist && (|dq[DIV_W-1:FIELD_W]);
    term      = zero_dist ? ZERO_DIST_TERM : dq[FIELD_W-1:0];
    sum_wide  = {1'b0, chain_in.sum} + {1'b0, term};
    sat_next  = chain_in.sat | over | sum_wide[FIELD_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid <= 1'b0;
    end else begin
      link_valid <= chain_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_in.valid) begin
      link_sum <= sat_next ? FIELD_MAX : sum_wide[FIELD_W-1:0];
      link_sat <= sat_next;
    end
  end

  assign chain_out = '{valid: link_valid, sum: link_sum, sat: link_sat};

endmodule
`default_nettype wire

### rtl/core/mbf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbf_ctrl: sequencer and result register
// Takes transactions, maps voxel indices to coordinates, steps the cell chain
// through its phases and hands the chain's final sum to the result register.
// ----------------------------------------------------------------------------
module mbf_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire logic                       command,
  input  wire logic [mbf_pkg::IDX_W-1:0]  voxel_col,
  input  wire logic [mbf_pkg::IDX_W-1:0]  voxel_row,
  input  wire logic [mbf_pkg::IDX_W-1:0]  voxel_slice,
  output mbf_pkg::ctl_t                   ctl,
  output mbf_pkg::vox_t                   vox,
  output mbf_pkg::link_t                  head,
  input  wire mbf_pkg::link_t             tail,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic [mbf_pkg::FIELD_W-1:0]     field_value,
  output logic                            field_saturated
);
  import mbf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_LEN  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIRE = 3'd5;
  localparam logic [2:0] ST_ACC  = 3'd6;
  localparam logic [2:0] ST_HOLD = 3'd7;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             accept, out_free;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && command == CMD_EVAL) state_next = ST_DIFF;
      end
      ST_DIFF: state_next = ST_SQR;
      ST_SQR:  state_next = ST_LEN;
      ST_LEN:  state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == DIV_LAST) state_next = ST_FIRE;
      end
      ST_FIRE: state_next = ST_ACC;
      ST_ACC: begin
        if (tail.valid) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LEN) begin
      cnt <= '0;
    end else if (state == ST_DIV) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vox.x <= coord_of(voxel_col);
      vox.y <= coord_of(voxel_row);
      vox.z <= coord_of(voxel_slice);
    end
  end

  assign ctl = '{diff_en: state == ST_DIFF, sq_en: state == ST_SQR,
                 len_en: state == ST_LEN, div_en: state == ST_DIV};

  assign head = '{valid: state == ST_FIRE, sum: '0, sat: 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      field_value     <= tail.sum;
      field_saturated <= tail.sat;
    end
  end

endmodule
`default_nettype wire

### rtl/core/metaball_field_eval_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// metaball_field_eval_top: inverse-square metaball field at grid voxels
//
// Input channel (item_valid / item_stall): a store transaction (command 0)
// writes energy and position of ball ball_slot; slots at or above BALL_COUNT
// are ignored. An evaluate transaction (command 1) names a voxel by three
// grid indices and returns one result on the output channel
// (result_valid / result_stall): the Q12.12 field sum, saturated, with a flag.
// Each ball lives in a cell of a chain; all cells divide in parallel and the
// partial sums then ripple from cell to cell.
// An evaluate steps through the sequencer states DIFF, SQR, LEN, DIV, FIRE,
// ACC and HOLD; the 38-step bit-serial divider in each cell dominates its
// latency. The next transaction is taken only once the result is in the
// output register. item_stall is high while an evaluate is in flight.
// A finished result waits in the output register while the next transaction
// is taken; a new result waits in the chain while result_stall is high.
// Reset clears the ball table to zero energy at the origin and empties the
// output register.
// ----------------------------------------------------------------------------
module metaball_field_eval_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic                          command,
  input  wire logic [mbf_pkg::SLOT_W-1:0]    ball_slot,
  input  wire logic [mbf_pkg::ENERGY_W-1:0]  ball_energy,
  input  wire logic signed [mbf_pkg::POS_W-1:0] ball_x,
  input  wire logic signed [mbf_pkg::POS_W-1:0] ball_y,
  input  wire logic signed [mbf_pkg::POS_W-1:0] ball_z,
  input  wire logic [mbf_pkg::IDX_W-1:0]     voxel_col,
  input  wire logic [mbf_pkg::IDX_W-1:0]     voxel_row,
  input  wire logic [mbf_pkg::IDX_W-1:0]     voxel_slice,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [mbf_pkg::FIELD_W-1:0]        field_value,
  output logic                               field_saturated
);
  import mbf_pkg::*;

  ctl_t  ctl;
  vox_t  vox;
  ball_t wr_ball;
  link_t links [BALL_COUNT+1];
  logic  store_acc;

  assign store_acc = item_valid && !item_stall && (command == CMD_STORE);
  assign wr_ball   = '{energy: ball_energy, x: ball_x, y: ball_y, z: ball_z};

  mbf_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .command         (command),
    .voxel_col       (voxel_col),
    .voxel_row       (voxel_row),
    .voxel_slice     (voxel_slice),
    .ctl             (ctl),
    .vox             (vox),
    .head            (links[0]),
    .tail            (links[BALL_COUNT]),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .field_value     (field_value),
    .field_saturated (field_saturated)
  );

  for (genvar k = 0; k < BALL_COUNT; k++) begin : g_cell
    logic wr_en;
    assign wr_en = store_acc && (int'(ball_slot) == k);

    mbf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (wr_en),
      .wr_ball   (wr_ball),
      .ctl       (ctl),
      .vox       (vox),
      .chain_in  (links[k]),
      .chain_out (links[k+1])
    );
  end

endmodule
`default_nettype wire

### rtl/core/mbf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbf_checker: port-level checks for the metaball field evaluator
// Watches the top level's handshakes and result fields over time.
// ----------------------------------------------------------------------------
module mbf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_stall,
  input wire logic        command,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [23:0] field_value,
  input wire logic        field_saturated
);

  // hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(field_value) && $stable(field_saturated))
    else $error("stalled result changed");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && field_saturated |-> field_value == 24'hFFFFFF)
    else $error("saturated result not at full scale");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // an evaluate transaction blocks the input until its result is formed
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && command |=> item_stall)
    else $error("input taken during evaluation");

endmodule

bind metaball_field_eval_top mbf_checker u_mbf_checker (
  .clk             (clk),
  .rst             (rst),
  .item_valid      (item_valid),
  .item_stall      (item_stall),
  .command         (command),
  .result_valid    (result_valid),
  .result_stall    (result_stall),
  .field_value     (field_value),
  .field_saturated (field_saturated)
);
`default_nettype wire
